// File: design/assert_macros.svh
// assertion helpers shared by the queue unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SSWQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define SSWQ_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SSWQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSWQ_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: design/sswq_pkg.sv
`default_nettype none
package sswq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TICK_W      = 48;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned DUR_W       = 32;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // action codes
  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  thread_id;
    logic [DUR_W-1:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic              woken_valid;
    logic [ID_W-1:0]   woken_thread;
    logic              last_result;
    logic              queue_full_reject;
    logic [TICK_W-1:0] current_tick;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } entry_t;

  // read address source, relative to the queue head
  typedef enum logic [1:0] {
    RD_POS,
    RD_POS_DEC,
    RD_HEAD0,
    RD_HEAD1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW_NEXT,
    WR_NEW_HERE
  } wr_op_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_EMPTY,
    EMIT_REJECT,
    EMIT_PEND,
    EMIT_RD
  } emit_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    logic    pos_dec;
    wr_op_t  wr_op;
    logic    count_inc;
    logic    pop;
    logic    pend_load;
    emit_t   emit;
    logic    emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
    logic pos_zero;
    logic later;
    logic due;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/sorted_sleep_wakeup_queue_unit.sv
`default_nettype none
// sorted sleep/wakeup queue: a saturating 48-bit tick counter plus up to
// QUEUE_DEPTH sleeping thread ids held in deadline order in one ram.
// an item is taken when start is high and busy is low; every result beat
// appears for exactly one cycle with out_strobe high and the receiver
// cannot stall it, so it must take each beat as it comes.
// a sleep item gives one beat; it scans from the queue tail towards the
// head, one entry per cycle over the ram's one read port and one write
// port, moving each entry that is due later one slot up; an empty or
// full queue is answered without a scan. busy stays high until the item
// is done. a tick item releases due entries from the head, one beat per
// cycle, until it meets an entry that is not yet due or the queue runs
// empty. the result beat is registered and appears in the cycle after
// the controller decides it.
module sorted_sleep_wakeup_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = sswq_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire sswq_pkg::in_item_t  in_item,
  output logic                     out_strobe,
  output sswq_pkg::out_item_t      out_item
);

  // command and status bundles between controller and datapath
  sswq_pkg::dp_cmd_t cmd;
  sswq_pkg::dp_sts_t sts;

  // controller: sequences insert scans and release bursts
  sswq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // datapath: counter, queue ram with head pointer, result register
  sswq_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

// File: design/sswq_ram.sv
`default_nettype none
module sswq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: design/sswq_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module sswq_datapath #(
  parameter int unsigned DEPTH = sswq_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sswq_pkg::in_item_t  in_item,
  input  wire sswq_pkg::dp_cmd_t   cmd,
  output sswq_pkg::dp_sts_t        sts,
  output logic                     out_strobe,
  output sswq_pkg::out_item_t      out_item
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned PAD_W = sswq_pkg::TICK_W + 1 - sswq_pkg::DUR_W;

  logic [sswq_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [sswq_pkg::TICK_W-1:0] dl_r, dl_nxt;
  logic [sswq_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [sswq_pkg::ID_W-1:0]   pend_r, pend_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sswq_pkg::out_item_t         out_item_r, out_item_nxt;

  logic [sswq_pkg::TICK_W:0]   dl_sum;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  sswq_pkg::entry_t            wr_data;
  logic [AW-1:0]               rd_addr;
  sswq_pkg::entry_t            rd_data;

  // logical queue slot to ram address, head-relative with one wrap
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lidx);
    logic [SW-1:0] sum;
    sum = {{(SW - AW){1'b0}}, head} + {1'b0, lidx};
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  sswq_ram #(
    .WIDTH ($bits(sswq_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    tick_nxt      = tick_r;
    dl_nxt        = dl_r;
    id_nxt        = id_r;
    pend_nxt      = pend_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    dl_sum = {1'b0, tick_r} + {{PAD_W{1'b0}}, in_item.sleep_ticks};

    if (cmd.load) begin
      id_nxt  = in_item.thread_id;
      dl_nxt  = dl_sum[sswq_pkg::TICK_W] ? sswq_pkg::TICK_MAX
                                         : dl_sum[sswq_pkg::TICK_W-1:0];
      pos_nxt = (count_r == '0) ? '0 : count_r - CW'(1);
      if (in_item.action == sswq_pkg::ACT_TICK && tick_r != sswq_pkg::TICK_MAX) begin
        tick_nxt = tick_r + sswq_pkg::TICK_W'(1);
      end
    end

    if (cmd.pos_dec) begin
      pos_nxt = pos_r - CW'(1);
    end

    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end

    if (cmd.pend_load) begin
      pend_nxt = rd_data.id;
    end

    // result register, current_tick always shows the updated counter
    out_item_nxt.current_tick = tick_r;
    unique case (cmd.emit)
      sswq_pkg::EMIT_NONE: begin
        out_valid_nxt = 1'b0;
      end
      sswq_pkg::EMIT_EMPTY: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.woken_valid       = 1'b0;
        out_item_nxt.woken_thread      = '0;
        out_item_nxt.last_result       = 1'b1;
        out_item_nxt.queue_full_reject = 1'b0;
      end
      sswq_pkg::EMIT_REJECT: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.woken_valid       = 1'b0;
        out_item_nxt.woken_thread      = '0;
        out_item_nxt.last_result       = 1'b1;
        out_item_nxt.queue_full_reject = 1'b1;
      end
      sswq_pkg::EMIT_PEND: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.woken_valid       = 1'b1;
        out_item_nxt.woken_thread      = pend_r;
        out_item_nxt.last_result       = cmd.emit_last;
        out_item_nxt.queue_full_reject = 1'b0;
      end
      sswq_pkg::EMIT_RD: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.woken_valid       = 1'b1;
        out_item_nxt.woken_thread      = rd_data.id;
        out_item_nxt.last_result       = cmd.emit_last;
        out_item_nxt.queue_full_reject = 1'b0;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      sswq_pkg::RD_POS:     rd_addr = phys(head_r, pos_r);
      sswq_pkg::RD_POS_DEC: rd_addr = phys(head_r, pos_r - CW'(1));
      sswq_pkg::RD_HEAD0:   rd_addr = head_r;
      sswq_pkg::RD_HEAD1:   rd_addr = phys(head_r, CW'(1));
      default:              rd_addr = head_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head_r, pos_r);
    wr_data = '{deadline: dl_r, id: id_r};
    unique case (cmd.wr_op)
      sswq_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      sswq_pkg::WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, pos_r + CW'(1));
        wr_data = rd_data;
      end
      sswq_pkg::WR_NEW_NEXT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, pos_r + CW'(1));
      end
      sswq_pkg::WR_NEW_HERE: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dl_r       <= dl_nxt;
    id_r       <= id_nxt;
    pend_r     <= pend_nxt;
    pos_r      <= pos_nxt;
    out_item_r <= out_item_nxt;
  end

  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.one_left = (count_r == CW'(1));
  assign sts.pos_zero = (pos_r == '0);
  assign sts.later    = (rd_data.deadline > dl_r);
  assign sts.due      = (rd_data.deadline <= tick_r);

  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  `SSWQ_NEVER(a_count_range, clk, rst_n, count_r > CW'(DEPTH), "entry count beyond depth")
  `SSWQ_ASSERT(a_pop_nonempty, clk, rst_n, cmd.pop |-> count_r != '0, "pop on empty queue")
  `SSWQ_ASSERT(a_wr_not_full, clk, rst_n, cmd.wr_op != sswq_pkg::WR_NONE |-> !sts.full, "write into full queue")
  `SSWQ_NEVER(a_wake_reject, clk, rst_n, out_valid_r && out_item_r.woken_valid && out_item_r.queue_full_reject, "wake and reject together")

endmodule
`default_nettype wire

// File: design/sswq_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module sswq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_action,
  input  wire sswq_pkg::dp_sts_t sts,
  output sswq_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLEEP_START,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_TICK_START,
    ST_TICK_FIRST,
    ST_TICK_SCAN,
    ST_TICK_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.rd_sel    = sswq_pkg::RD_POS;
    cmd.pos_dec   = 1'b0;
    cmd.wr_op     = sswq_pkg::WR_NONE;
    cmd.count_inc = 1'b0;
    cmd.pop       = 1'b0;
    cmd.pend_load = 1'b0;
    cmd.emit      = sswq_pkg::EMIT_NONE;
    cmd.emit_last = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == sswq_pkg::ACT_TICK) ? ST_TICK_START : ST_SLEEP_START;
        end
      end
      ST_SLEEP_START: begin
        if (sts.full) begin
          cmd.emit  = sswq_pkg::EMIT_REJECT;
          state_nxt = ST_IDLE;
        end else if (sts.empty) begin
          cmd.wr_op     = sswq_pkg::WR_NEW_HERE;
          cmd.count_inc = 1'b1;
          cmd.emit      = sswq_pkg::EMIT_EMPTY;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rd_sel = sswq_pkg::RD_POS;
          state_nxt  = ST_INS_SCAN;
        end
      end
      ST_INS_SCAN: begin
        if (sts.later) begin
          cmd.wr_op = sswq_pkg::WR_SHIFT;
          if (sts.pos_zero) begin
            state_nxt = ST_INS_PUT;
          end else begin
            cmd.rd_sel  = sswq_pkg::RD_POS_DEC;
            cmd.pos_dec = 1'b1;
          end
        end else begin
          cmd.wr_op     = sswq_pkg::WR_NEW_NEXT;
          cmd.count_inc = 1'b1;
          cmd.emit      = sswq_pkg::EMIT_EMPTY;
          state_nxt     = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        cmd.wr_op     = sswq_pkg::WR_NEW_HERE;
        cmd.count_inc = 1'b1;
        cmd.emit      = sswq_pkg::EMIT_EMPTY;
        state_nxt     = ST_IDLE;
      end
      ST_TICK_START: begin
        if (sts.empty) begin
          cmd.emit  = sswq_pkg::EMIT_EMPTY;
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_sel = sswq_pkg::RD_HEAD0;
          state_nxt  = ST_TICK_FIRST;
        end
      end
      ST_TICK_FIRST: begin
        if (sts.due) begin
          cmd.pop = 1'b1;
          if (sts.one_left) begin
            cmd.emit      = sswq_pkg::EMIT_RD;
            cmd.emit_last = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.pend_load = 1'b1;
            cmd.rd_sel    = sswq_pkg::RD_HEAD1;
            state_nxt     = ST_TICK_SCAN;
          end
        end else begin
          cmd.emit  = sswq_pkg::EMIT_EMPTY;
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK_SCAN: begin
        cmd.emit = sswq_pkg::EMIT_PEND;
        if (sts.due) begin
          cmd.pend_load = 1'b1;
          cmd.pop       = 1'b1;
          if (sts.one_left) begin
            state_nxt = ST_TICK_FLUSH;
          end else begin
            cmd.rd_sel = sswq_pkg::RD_HEAD1;
          end
        end else begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TICK_FLUSH: begin
        cmd.emit      = sswq_pkg::EMIT_PEND;
        cmd.emit_last = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  `SSWQ_ASSERT(a_busy_state, clk, rst_n, busy_r == (state_r != ST_IDLE), "busy out of step with state")
  `SSWQ_NEVER(a_inc_and_pop, clk, rst_n, cmd.count_inc && cmd.pop, "insert and release together")
  `SSWQ_ASSERT(a_last_to_idle, clk, rst_n, (cmd.emit != sswq_pkg::EMIT_NONE && (cmd.emit_last || cmd.emit == sswq_pkg::EMIT_EMPTY || cmd.emit == sswq_pkg::EMIT_REJECT)) |=> state_r == ST_IDLE, "final beat not closing the item")

endmodule
`default_nettype wire

// File: sim/sswq_wakeup_checker.sv
`timescale 1ns / 100ps
module sswq_wakeup_checker
  import sswq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_strobe,
  input  wire out_item_t out_item,
  output int unsigned    mismatches,
  output int unsigned    beats_owed
);

  // shadow of the sleeper queue, kept sorted by deadline
  logic [TICK_W-1:0] now_tick;
  logic [TICK_W-1:0] wake_at [QUEUE_DEPTH];
  logic [ID_W-1:0]   wake_id [QUEUE_DEPTH];
  int                queued;
  out_item_t         due_beats[$];
  out_item_t         want;

  task automatic forecast_wakeups(input in_item_t it);
    out_item_t         r;
    logic [TICK_W:0]   sum;
    logic [TICK_W-1:0] dl;
    int                slot;
    int                ready;
    r = '0;
    r.last_result = 1'b1;
    if (it.action == ACT_SLEEP) begin
      if (queued >= int'(QUEUE_DEPTH)) begin
        r.queue_full_reject = 1'b1;
      end else begin
        sum = {1'b0, now_tick} + it.sleep_ticks;
        dl = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
        // first entry due strictly later, else the tail
        slot = queued;
        for (int i = queued - 1; i >= 0; i--) begin
          if (wake_at[i] > dl) slot = i;
        end
        for (int i = queued; i > slot; i--) begin
          wake_at[i] = wake_at[i-1];
          wake_id[i] = wake_id[i-1];
        end
        wake_at[slot] = dl;
        wake_id[slot] = it.thread_id;
        queued++;
      end
      r.current_tick = now_tick;
      due_beats.push_back(r);
    end else begin
      if (now_tick != TICK_MAX) now_tick++;
      ready = 0;
      while (ready < queued && wake_at[ready] <= now_tick) ready++;
      r.current_tick = now_tick;
      if (ready == 0) begin
        due_beats.push_back(r);
      end else begin
        for (int i = 0; i < ready; i++) begin
          r.woken_valid  = 1'b1;
          r.woken_thread = wake_id[i];
          r.last_result  = (i == ready - 1);
          due_beats.push_back(r);
        end
        for (int i = ready; i < queued; i++) begin
          wake_at[i-ready] = wake_at[i];
          wake_id[i-ready] = wake_id[i];
        end
        queued -= ready;
      end
    end
  endtask

  task automatic match_field(input string fname, input logic [TICK_W-1:0] exp_v,
                             input logic [TICK_W-1:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0h got %0h", $time, fname, exp_v, got_v);
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      now_tick = '0;
      queued = 0;
      due_beats.delete();
    end else begin
      if (out_strobe) begin
        if (due_beats.size() == 0) begin
          mismatches++;
          $display("%0t ns: beat with none expected, actual %h", $time, out_item);
        end else begin
          want = due_beats.pop_front();
          match_field("woken_valid", TICK_W'(want.woken_valid), TICK_W'(out_item.woken_valid));
          match_field("woken_thread", TICK_W'(want.woken_thread),
                      TICK_W'(out_item.woken_thread));
          match_field("last_result", TICK_W'(want.last_result), TICK_W'(out_item.last_result));
          match_field("queue_full_reject", TICK_W'(want.queue_full_reject),
                      TICK_W'(out_item.queue_full_reject));
          match_field("current_tick", want.current_tick, out_item.current_tick);
        end
      end
      if (start && !busy) forecast_wakeups(in_item);
    end
    beats_owed = due_beats.size();
  end

endmodule

// File: sim/tb_sorted_sleep_wakeup_queue_unit.sv
`timescale 1ns / 100ps
module tb_sorted_sleep_wakeup_queue_unit;
  import sswq_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned beats_owed;

  // no-gap mode, flipped now and then so some stretches run back to back
  bit          eager;
  // durations that can never expire in this run eat a slot for good
  int          long_sleepers;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_sleep_wakeup_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  sswq_wakeup_checker wakeup_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .mismatches(mismatches),
    .beats_owed(beats_owed)
  );

  function automatic in_item_t sleep_req(input logic [ID_W-1:0] id,
                                         input logic [DUR_W-1:0] dur);
    in_item_t it;
    it.action      = ACT_SLEEP;
    it.thread_id   = id;
    it.sleep_ticks = dur;
    return it;
  endfunction

  // the id and duration fields are don't-care on a tick, so fill them with noise
  function automatic in_item_t tick_req();
    in_item_t it;
    it.action      = ACT_TICK;
    it.thread_id   = ID_W'($urandom_range(0, 255));
    it.sleep_ticks = $urandom;
    return it;
  endfunction

  // mostly short sleeps so entries come due within a burst of ticks,
  // now and then a longer one, and very rarely the full 32-bit range
  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0 && long_sleepers < 3) begin
      long_sleepers++;
      return $urandom;
    end
    if (r < 10) return $urandom_range(13, 60);
    return $urandom_range(0, 12);
  endfunction

  // mostly back to back or short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken.
  // busy is looked at on the falling edge, where it is stable until the next rise;
  // start is only raised once busy is low, so the beat is taken exactly once
  task automatic issue(input in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (busy || gap != 0) begin
      start <= 1'b0;
      while (busy) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(negedge clk);
  endtask

  initial begin
    int n;
    int sent;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    eager   = 1'b0;
    long_sleepers = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: tick on an empty queue
    issue(tick_req());
    // zero duration comes due on the very next tick, extreme ids
    issue(sleep_req(8'h00, 32'd0));
    // widest duration, never expires in this run
    issue(sleep_req(8'hFF, 32'hFFFF_FFFF));
    // equal deadlines must leave in arrival order
    issue(sleep_req(8'h5A, 32'd2));
    issue(sleep_req(8'hA5, 32'd2));
    // earlier deadline slots in ahead of them
    issue(sleep_req(8'h07, 32'd1));
    issue(tick_req());
    issue(tick_req());
    // fill every slot with a mix of two deadlines, then one more is refused
    for (int k = 0; k < 15; k++) issue(sleep_req(ID_W'(8'h10 + k), DUR_W'(k & 1)));
    issue(sleep_req(8'hC3, 32'd0));
    // one tick releases a long run of sleepers
    issue(tick_req());

    // random: mostly a run of sleepers followed by ticks that wake them,
    // with some shuffled noise in between
    sent = 0;
    while (sent < 350) begin
      if ($urandom_range(0, 3) == 0) eager = !eager;
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(1, 17);
        repeat (n) issue(sleep_req(ID_W'($urandom_range(0, 255)), pick_duration()));
        sent += n;
        n = $urandom_range(1, 12);
        repeat (n) issue(tick_req());
        sent += n;
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0)
            issue(sleep_req(ID_W'($urandom_range(0, 255)), $urandom_range(0, 40)));
          else
            issue(tick_req());
        end
        sent += n;
      end
    end
    start <= 1'b0;

    // drain, then leave room for any stray beat
    while (beats_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
